>>> src/exponential_search_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// exponential search engine assertion macros
// shared concurrent assertion forms for the search engine modules
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_SEARCH_ENGINE_UNIT_MACROS_SVH
`define EXPONENTIAL_SEARCH_ENGINE_UNIT_MACROS_SVH

// property holds at every edge out of reset
`define ESEU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds at the edge after the antecedent
`define ESEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/esu_pkg.sv
// ----------------------------------------------------------------------------
// esu_pkg
// widths, codes and types shared by the exponential search engine
// ----------------------------------------------------------------------------
package esu_pkg;

  localparam int DEPTH_DEF = 1024;

  localparam int KEY_W   = 32;
  localparam int IDX_W   = 10;
  localparam int LEN_W   = 11;
  // probe can reach twice the largest length
  localparam int PROBE_W = LEN_W + 1;
  // signed search bounds, hi may drop to -1
  localparam int BOUND_W = PROBE_W + 1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // register index taken from paddr above the byte offset
  localparam logic REG_LENGTH = 1'b0;

  localparam logic signed [BOUND_W-1:0] BOUND_ONE = BOUND_W'(1);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } result_t;

endpackage

>>> src/exponential_search_engine_unit.sv
// ----------------------------------------------------------------------------
// exponential_search_engine_unit
// sorted key store with exponential search, apb length register
// ----------------------------------------------------------------------------
// A write word (cmd 0) stores key at index and gives no result; an index at
// or above DEPTH is dropped. A search word (cmd 1) tests entry 0, doubles a
// probe while it is below length and its entry is at most the key, then
// binary searches the bracketed range, and returns found and position. The
// store is one RAM with a single read port and a registered read, and each
// probe needs the previous probe's data, so a search issues at most one read
// per cycle, and in_stall holds new words while it runs. Entries are
// undefined until written; keep entries 0 to length-1 written and ascending.
// Write length only while the block is idle.
// ----------------------------------------------------------------------------
module exponential_search_engine_unit #(
  parameter int DEPTH = esu_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [esu_pkg::PADDR_W-1:0]        paddr,
  input  logic [esu_pkg::PDATA_W-1:0]        pwdata,
  output logic [esu_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [esu_pkg::IDX_W-1:0]          index,
  input  logic signed [esu_pkg::KEY_W-1:0]   key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [esu_pkg::IDX_W-1:0]          position
);

  logic [esu_pkg::LEN_W-1:0]         length;
  logic [esu_pkg::LEN_W-1:0]         len_wr;
  logic                              len_we;
  logic                              accept;
  logic                              wr_en;
  logic                              start;
  logic                              busy;
  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic signed [esu_pkg::KEY_W-1:0]  rd_data;
  logic                              res_valid;
  logic                              res_take;
  esu_pkg::result_t                  res;

  assign pready = 1'b1;
  assign len_we = psel && penable && pwrite
                  && (paddr[esu_pkg::PADDR_W-1:2] == esu_pkg::REG_LENGTH);
  assign len_wr = pwdata[esu_pkg::LEN_W-1:0];
  assign prdata = (paddr[esu_pkg::PADDR_W-1:2] == esu_pkg::REG_LENGTH)
                  ? esu_pkg::PDATA_W'(length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (len_we) begin
      length <= (32'(len_wr) > DEPTH) ? esu_pkg::LEN_W'(DEPTH) : len_wr;
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (cmd == esu_pkg::CMD_WRITE) && (32'(index) < DEPTH);
  assign start    = accept && (cmd == esu_pkg::CMD_SEARCH);

  esu_ram #(
    .WIDTH(esu_pkg::KEY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(index)),
    .wdata(key),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  esu_search #(
    .DEPTH(DEPTH)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .key      (key),
    .length   (length),
    .rd_data  (rd_data),
    .res_take (res_take),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .res_valid(res_valid),
    .res      (res)
  );

  // output slot frees when empty or being taken
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_take) begin
      found    <= res.found;
      position <= res.position;
    end
  end

endmodule

>>> src/esu_ram.sv
// ----------------------------------------------------------------------------
// esu_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module esu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/esu_search.sv
// ----------------------------------------------------------------------------
// esu_search
// probe sequencer: entry zero test, doubling phase, then binary phase
// ----------------------------------------------------------------------------
`include "exponential_search_engine_unit_macros.svh"

module esu_search #(
  parameter int DEPTH = esu_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [esu_pkg::KEY_W-1:0]  key,
  input  logic [esu_pkg::LEN_W-1:0]         length,
  input  logic signed [esu_pkg::KEY_W-1:0]  rd_data,
  input  logic                              res_take,
  output logic                              busy,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  output logic                              res_valid,
  output esu_pkg::result_t                  res
);

  localparam int PW = esu_pkg::PROBE_W;
  localparam int BW = esu_pkg::BOUND_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK0 = 6'b000010,
    S_DOUBLE = 6'b000100,
    S_BSETUP = 6'b001000,
    S_BCHECK = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                            state, state_next;
  logic signed [esu_pkg::KEY_W-1:0]  key_q;
  logic [PW-1:0]                     probe, probe_next;
  logic signed [BW-1:0]              lo, lo_next;
  logic signed [BW-1:0]              hi, hi_next;
  logic signed [BW-1:0]              mid, mid_next;
  logic                              hit, hit_next;

  logic [PW-1:0]        len_p;
  logic [PW-1:0]        probe_x2;
  logic [PW-1:0]        rd_idx;
  logic signed [BW-1:0] len_s;
  logic signed [BW-1:0] len_m1;
  logic signed [BW-1:0] probe_s;
  logic signed [BW-1:0] lo_s;
  logic signed [BW-1:0] hi_s;
  logic signed [BW-1:0] lo_n;
  logic signed [BW-1:0] hi_n;
  logic                 eq;
  logic                 lt;

  function automatic logic signed [BW-1:0] mid_of(input logic signed [BW-1:0] a,
                                                  input logic signed [BW-1:0] b);
    logic signed [BW-1:0] d;
    d = b - a;
    return a + (d >>> 1);
  endfunction

  assign len_p    = PW'(length);
  assign len_s    = $signed(BW'(length));
  assign len_m1   = len_s - esu_pkg::BOUND_ONE;
  assign probe_x2 = {probe[PW-2:0], 1'b0};
  assign probe_s  = $signed(BW'(probe));
  assign lo_s     = $signed(BW'(probe >> 1));
  assign hi_s     = (probe_s < len_m1) ? probe_s : len_m1;
  assign eq       = (rd_data == key_q);
  assign lt       = (rd_data < key_q);
  assign lo_n     = lt ? (mid + esu_pkg::BOUND_ONE) : lo;
  assign hi_n     = lt ? hi : (mid - esu_pkg::BOUND_ONE);

  always_comb begin
    state_next = state;
    probe_next = probe;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    hit_next   = hit;
    rd_en      = 1'b0;
    rd_idx     = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (length == '0) begin
            hit_next   = 1'b0;
            state_next = S_DONE;
          end else begin
            rd_en      = 1'b1;
            state_next = S_CHECK0;
          end
        end
      end
      S_CHECK0: begin
        if (eq) begin
          hit_next   = 1'b1;
          mid_next   = '0;
          state_next = S_DONE;
        end else begin
          probe_next = PW'(1);
          if (PW'(1) < len_p) begin
            rd_en      = 1'b1;
            rd_idx     = PW'(1);
            state_next = S_DOUBLE;
          end else begin
            state_next = S_BSETUP;
          end
        end
      end
      S_DOUBLE: begin
        if (!lt && !eq) begin
          state_next = S_BSETUP;
        end else begin
          probe_next = probe_x2;
          if (probe_x2 < len_p) begin
            rd_en  = 1'b1;
            rd_idx = probe_x2;
          end else begin
            state_next = S_BSETUP;
          end
        end
      end
      S_BSETUP: begin
        lo_next    = lo_s;
        hi_next    = hi_s;
        mid_next   = mid_of(lo_s, hi_s);
        rd_en      = 1'b1;
        rd_idx     = PW'($unsigned(mid_next));
        state_next = S_BCHECK;
      end
      S_BCHECK: begin
        if (eq) begin
          hit_next   = 1'b1;
          state_next = S_DONE;
        end else if (lo_n <= hi_n) begin
          lo_next  = lo_n;
          hi_next  = hi_n;
          mid_next = mid_of(lo_n, hi_n);
          rd_en    = 1'b1;
          rd_idx   = PW'($unsigned(mid_next));
        end else begin
          hit_next   = 1'b0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (start && state == S_IDLE) begin
      key_q <= key;
    end
    probe <= probe_next;
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
    hit   <= hit_next;
  end

  assign busy         = (state != S_IDLE);
  assign rd_addr      = AW'(rd_idx);
  assign res_valid    = (state == S_DONE);
  assign res.found    = hit;
  assign res.position = hit ? esu_pkg::IDX_W'($unsigned(mid)) : '0;

  `ESEU_ASSERT(a_read_in_range, clk, rst, rd_en |-> (rd_idx < len_p), "read past length")
  `ESEU_ASSERT(a_bounds_ordered, clk, rst, (state == S_BCHECK) |-> (lo <= mid && mid <= hi),
    "binary probe outside its range")
  `ESEU_ASSERT(a_hit_in_range, clk, rst,
    (res_valid && res.found) |-> (mid >= $signed(BW'(0)) && mid < len_s),
    "hit position past length")
  `ESEU_ASSERT_NEXT(a_result_held, clk, rst, res_valid && !res_take,
    res_valid && $stable(res), "result dropped before taken")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// exponential search engine testbench
// loads sorted, duplicate-heavy and unsorted key stores through write words,
// sets the length register over apb and checks every search result against
// an exponential search predictor kept in step with the accepted words
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = esu_pkg::DEPTH_DEF;
  localparam int KEY_W          = esu_pkg::KEY_W;
  localparam int IDX_W          = esu_pkg::IDX_W;
  localparam int LEN_W          = esu_pkg::LEN_W;
  localparam int PADDR_W        = esu_pkg::PADDR_W;
  localparam int PDATA_W        = esu_pkg::PDATA_W;
  localparam int WAIT_MAX       = 9;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1850;
  localparam int REPORT_MAX     = 10;

  localparam logic [PADDR_W-1:0] LEN_ADDR = {esu_pkg::REG_LENGTH, 2'b00};
  localparam logic [PADDR_W-1:0] BAD_ADDR = {!esu_pkg::REG_LENGTH, 2'b00};

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      psel     = 1'b0;
  logic                      penable  = 1'b0;
  logic                      pwrite   = 1'b0;
  logic [PADDR_W-1:0]        paddr    = '0;
  logic [PDATA_W-1:0]        pwdata   = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      cmd      = esu_pkg::CMD_WRITE;
  logic [IDX_W-1:0]          index    = '0;
  logic signed [KEY_W-1:0]   key      = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      found;
  logic [IDX_W-1:0]          position;

  exponential_search_engine_unit i_dut (.*);

  logic signed [KEY_W-1:0] key_store [DEPTH];
  int                      model_len;
  esu_pkg::result_t        pending_results [$];
  int                      mismatch_cnt = 0;
  int                      item_cnt     = 0;
  int                      idle_cycles  = 0;
  int                      stall_left   = 0;
  bit                      burst_mode   = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic esu_pkg::result_t predict_search(logic signed [KEY_W-1:0] k);
    esu_pkg::result_t r;
    int probe, lo, hi, mid;
    r = '0;
    if (model_len == 0) return r;
    if (key_store[0] == k) begin
      r.found = 1'b1;
      return r;
    end
    probe = 1;
    while (probe < model_len && key_store[probe] <= k) probe = probe * 2;
    lo = probe / 2;
    hi = (probe < model_len - 1) ? probe : model_len - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_store[mid] == k) begin
        r.found    = 1'b1;
        r.position = IDX_W'(mid);
        return r;
      end
      if (key_store[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    int sel;
    logic signed [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    k   = (model_len > 0) ? key_store[$urandom_range(0, model_len - 1)] : KEY_W'($urandom);
    if (sel < 55) return k;
    else if (sel < 68) return k + 1;
    else if (sel < 80) return k - 1;
    else if (sel < 90) return KEY_W'($urandom);
    else if (sel < 95) return KEY_MIN;
    else return KEY_MAX;
  endfunction

  // one word per call, predictor updated at the accepting edge
  task automatic send_word(input logic c, input logic [IDX_W-1:0] i,
                           input logic signed [KEY_W-1:0] k);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, WAIT_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    index    <= i;
    key      <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == esu_pkg::CMD_WRITE) key_store[i] = k;
    else pending_results.push_back(predict_search(k));
    item_cnt++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_length_reg();
    logic [PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LEN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== PDATA_W'(model_len)) note_mismatch("length readback", model_len, got);
  endtask

  task automatic set_length(input logic [PDATA_W-1:0] d);
    apb_write(LEN_ADDR, d);
    model_len = (d[LEN_W-1:0] > DEPTH) ? DEPTH : int'(d[LEN_W-1:0]);
  endtask

  // non-descending keys from entry 0, optionally pinned to the key extremes
  task automatic fill_sorted(input int n, input int unsigned step_max, input bit pin_ends);
    longint level;
    level = pin_ends ? longint'(KEY_MIN) : longint'($signed(KEY_W'($urandom))) / 2;
    for (int j = 0; j < n; j++) begin
      if (pin_ends && j == n - 1) level = KEY_MAX;
      send_word(esu_pkg::CMD_WRITE, IDX_W'(j), KEY_W'(level));
      level = level + longint'($urandom_range(0, step_max));
      if (level > KEY_MAX) level = KEY_MAX;
    end
  endtask

  task automatic fill_unsorted(input int n);
    for (int j = 0; j < n; j++) send_word(esu_pkg::CMD_WRITE, IDX_W'(j), KEY_W'($urandom));
  endtask

  // searches with a little write noise mixed in
  task automatic run_searches(input int n);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 99) < 5)
        send_word(esu_pkg::CMD_WRITE, IDX_W'($urandom), KEY_W'($urandom));
      else
        send_word(esu_pkg::CMD_SEARCH, IDX_W'($urandom), pick_key());
    end
  endtask

  task automatic test_empty_store();
    check_length_reg();
    send_word(esu_pkg::CMD_SEARCH, '0, KEY_MIN);
    wait_idle();
    set_length('0);
    check_length_reg();
    send_word(esu_pkg::CMD_SEARCH, '1, KEY_MAX);
    wait_idle();
  endtask

  task automatic test_edge_keys();
    send_word(esu_pkg::CMD_WRITE, IDX_W'(0), KEY_MIN);
    send_word(esu_pkg::CMD_WRITE, IDX_W'(1), -1);
    send_word(esu_pkg::CMD_WRITE, IDX_W'(2), 0);
    send_word(esu_pkg::CMD_WRITE, IDX_W'(3), 1);
    send_word(esu_pkg::CMD_WRITE, IDX_W'(4), KEY_MAX);
    wait_idle();
    set_length(5);
    check_length_reg();
    send_word(esu_pkg::CMD_SEARCH, '0, KEY_MIN);
    send_word(esu_pkg::CMD_SEARCH, '0, -1);
    send_word(esu_pkg::CMD_SEARCH, '0, 0);
    send_word(esu_pkg::CMD_SEARCH, '0, 1);
    send_word(esu_pkg::CMD_SEARCH, '0, KEY_MAX);
    send_word(esu_pkg::CMD_SEARCH, '0, 2);
    send_word(esu_pkg::CMD_SEARCH, '0, KEY_MIN + 1);
    send_word(esu_pkg::CMD_SEARCH, '0, KEY_MAX - 1);
    wait_idle();
    set_length(1);
    send_word(esu_pkg::CMD_SEARCH, '0, KEY_MIN);
    send_word(esu_pkg::CMD_SEARCH, '0, KEY_MAX);
    wait_idle();
  endtask

  task automatic test_bad_register();
    apb_write(BAD_ADDR, 5);
    check_length_reg();
    send_word(esu_pkg::CMD_SEARCH, '0, KEY_MAX);
    wait_idle();
    set_length({{(PDATA_W-LEN_W){1'b1}}, LEN_W'(5)});
    send_word(esu_pkg::CMD_SEARCH, '0, KEY_MAX);
    wait_idle();
  endtask

  task automatic test_full_store();
    burst_mode = 1'b1;
    fill_sorted(DEPTH, 1 << 23, 1'b1);
    wait_idle();
    burst_mode = 1'b0;
    set_length(DEPTH);
    check_length_reg();
    run_searches(120);
    wait_idle();
    // length above the store depth acts as the full store
    set_length({PDATA_W'($urandom) << LEN_W} | PDATA_W'(2047));
    run_searches(40);
    wait_idle();
    burst_mode = 1'b1;
    set_length(DEPTH - 1);
    check_length_reg();
    run_searches(30);
    wait_idle();
    burst_mode = 1'b0;
    set_length(513);
    run_searches(30);
    wait_idle();
  endtask

  task automatic test_small_stores();
    int style, len;
    logic [PDATA_W-1:0] d;
    while (item_cnt < ITEM_TARGET) begin
      style      = $urandom_range(0, 9);
      len        = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 48);
      burst_mode = ($urandom_range(0, 3) == 0);
      case (style)
        0: begin
          fill_unsorted(len);
        end
        1: begin
          fill_sorted(len, 0, 1'b0);
        end
        2: begin
          fill_sorted(len, 2, 1'b0);
        end
        3: begin
          fill_sorted(len, 1 << 26, 1'b1);
        end
        9: begin
          len = $urandom_range(49, 200);
          fill_sorted(len, 1 << 20, 1'b0);
        end
        default: begin
          fill_sorted(len, $urandom_range(1, 1 << 16), 1'($urandom_range(0, 1)));
        end
      endcase
      wait_idle();
      d = (PDATA_W'($urandom) << LEN_W) | PDATA_W'(len);
      set_length(d);
      if ($urandom_range(0, 3) == 0) check_length_reg();
      run_searches($urandom_range(10, 30));
      wait_idle();
    end
  endtask

  // result side: random stall per word, compare against oldest prediction
  always @(posedge clk) begin
    esu_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, {found, position});
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) note_mismatch("found", want.found, found);
        if (position !== want.position) note_mismatch("position", want.position, position);
      end
      stall_left = burst_mode ? 0 : $urandom_range(0, WAIT_MAX);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** exponential_search_engine_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    model_len = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_edge_keys();
    test_bad_register();
    test_full_store();
    test_small_stores();
    wait_idle();
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("** exponential_search_engine_unit: PASSED **");
    end else begin
      $display("** exponential_search_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
